// ===== hw/rtl/lqrp_pkg.sv =====
// Types, character codes and helpers shared by the link-quality line parser.
`timescale 1ns / 1ps

package lqrp_pkg;

	localparam logic [7:0] CH_NUL     = 8'h00;
	localparam logic [7:0] CH_NEWLINE = 8'h0A;
	localparam logic [7:0] CH_COLON   = 8'h3A;
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_ONE     = 8'h31;
	localparam logic [7:0] CH_TWO     = 8'h32;
	localparam logic [7:0] CH_FIVE    = 8'h35;
	localparam logic [7:0] CH_NINE    = 8'h39;
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_UPPER_F = 8'h46;

	localparam logic [1:0] ROUTER_0    = 2'd0;
	localparam logic [1:0] ROUTER_1    = 2'd1;
	localparam logic [1:0] ROUTER_NONE = 2'd2;

	typedef enum logic [3:0] {
		ST_LEAD    = 4'd0,
		ST_ROUTER  = 4'd1,
		ST_COLON_A = 4'd2,
		ST_ZERO_B  = 4'd3,
		ST_LINK    = 4'd4,
		ST_COLON_C = 4'd5,
		ST_HEX_HI  = 4'd6,
		ST_HEX_LO  = 4'd7,
		ST_SKIP_A1 = 4'd8,
		ST_SKIP_A2 = 4'd9,
		ST_SKIP_B1 = 4'd10,
		ST_SKIP_B2 = 4'd11
	} parse_state_t;

	// One parsed beat: hit marks a reportable link-quality line.
	typedef struct packed {
		logic       hit;
		logic [1:0] link_index;
		logic [7:0] quality;
	} lqrp_result_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] value;
	} hex_digit_t;

	// Uppercase hex only; lowercase is not a digit here.
	function automatic hex_digit_t hex_decode(input logic [7:0] c);
		hex_digit_t d;
		d.ok    = 1'b0;
		d.value = 4'd0;
		if (c >= CH_ZERO && c <= CH_NINE) begin
			d.ok    = 1'b1;
			d.value = 4'(c - CH_ZERO);
		end else if (c >= CH_UPPER_A && c <= CH_UPPER_F) begin
			d.ok    = 1'b1;
			d.value = 4'(c - CH_UPPER_A + 8'd10);
		end
		return d;
	endfunction

endpackage

// ===== hw/rtl/lqrp_parser.sv =====
// Line-position state machine and result decode for the link-quality parser.
`timescale 1ns / 1ps

module lqrp_parser (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  logic [7:0]            rx_byte,
	output lqrp_pkg::lqrp_result_t result
);
	import lqrp_pkg::*;

	parse_state_t state_q, state_d;
	logic [1:0]   router_q, router_d;
	logic [1:0]   link_q, link_d;
	logic [3:0]   nib_q, nib_d;
	hex_digit_t   hex;
	logic         pair_ok;

	assign hex = hex_decode(rx_byte);
	assign pair_ok = (router_q == ROUTER_0 && !link_q[1]) ||
	                 (router_q == ROUTER_1 &&  link_q[1]);

	// next state
	always_comb begin
		state_d  = state_q;
		router_d = router_q;
		link_d   = link_q;
		nib_d    = nib_q;
		if (rx_byte == CH_NEWLINE) begin
			state_d  = ST_LEAD;
			router_d = ROUTER_NONE;
			link_d   = 2'd0;
			nib_d    = 4'd0;
		end else if (rx_byte != CH_NUL) begin
			case (state_q)
				ST_LEAD: begin
					if (rx_byte == CH_ZERO) state_d = ST_ROUTER;
				end
				ST_ROUTER: begin
					if (rx_byte == CH_ZERO || rx_byte == CH_ONE) begin
						router_d = {1'b0, rx_byte[0]};
						state_d  = ST_SKIP_A1;
					end
				end
				ST_SKIP_A1: state_d = ST_SKIP_A2;
				ST_SKIP_A2: state_d = ST_COLON_A;
				ST_COLON_A: begin
					if (rx_byte == CH_COLON) state_d = ST_SKIP_B1;
				end
				ST_SKIP_B1: state_d = ST_SKIP_B2;
				ST_SKIP_B2: state_d = ST_ZERO_B;
				ST_ZERO_B: begin
					if (rx_byte == CH_ZERO) state_d = ST_LINK;
				end
				ST_LINK: begin
					if (rx_byte >= CH_TWO && rx_byte <= CH_FIVE) begin
						link_d  = 2'(rx_byte - CH_TWO);
						state_d = ST_COLON_C;
					end
				end
				ST_COLON_C: begin
					if (rx_byte == CH_COLON) state_d = ST_HEX_HI;
				end
				ST_HEX_HI: begin
					if (hex.ok) begin
						nib_d   = hex.value;
						state_d = ST_HEX_LO;
					end
				end
				ST_HEX_LO: begin
					if (hex.ok) begin
						state_d  = ST_LEAD;
						router_d = ROUTER_NONE;
						link_d   = 2'd0;
						nib_d    = 4'd0;
					end
				end
				default: state_d = state_q;
			endcase
		end
	end

	// outputs
	always_comb begin
		result.hit        = 1'b0;
		result.link_index = link_q;
		result.quality    = {nib_q, hex.value};
		case (state_q)
			ST_HEX_LO: result.hit = hex.ok && pair_ok;
			default:   result.hit = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_LEAD;
			router_q <= ROUTER_NONE;
			link_q   <= 2'd0;
			nib_q    <= 4'd0;
		end else if (step) begin
			state_q  <= state_d;
			router_q <= router_d;
			link_q   <= link_d;
			nib_q    <= nib_d;
		end
	end

endmodule

// ===== hw/rtl/link_quality_report_parser_core.sv =====
// Top level of the link-quality line parser: input register, parser, result register.
//
// Usage:
//   Input channel carries one received ASCII byte per beat (rx_byte, in_valid,
//   in_stall). Output channel carries one link report per beat (link_index,
//   quality, out_valid, out_stall). A beat moves when valid is high and stall
//   is low at a rising clk edge.
//   Only the final hex digit of a matching line produces an output beat; all
//   other bytes update the parse and produce nothing.
//   A byte accepted into the input register is parsed when step fires, and its
//   report is registered in the result register, raising out_valid.
//   Throughput: one byte per cycle while no report is held stalled, set by the
//   single parse step between the input register and the result register.
//   When the receiver stalls with a report held, the input register fills and
//   in_stall rises until the report is taken; held payloads do not change.
//   Reset (arst_n low) clears the valid flags of both registers and returns the
//   parse to its start, waiting for the leading '0', with no router recorded.
`timescale 1ns / 1ps

module link_quality_report_parser_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] rx_byte,
	input  logic       in_valid,
	output logic       in_stall,
	output logic [1:0] link_index,
	output logic [7:0] quality,
	output logic       out_valid,
	input  logic       out_stall
);
	import lqrp_pkg::*;

	logic         valid_s1;
	logic [7:0]   byte_s1;
	logic         out_free;
	logic         step;
	lqrp_result_t res;

	assign out_free = !out_valid || !out_stall;
	assign step     = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= rx_byte;
		end
	end

	lqrp_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.rx_byte (byte_s1),
		.result  (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_free) begin
			out_valid <= step && res.hit;
		end
	end

	always_ff @(posedge clk) begin
		if (step && res.hit) begin
			link_index <= res.link_index;
			quality    <= res.quality;
		end
	end

endmodule

// ===== hw/rtl/lqrp_checker.sv =====
// Port-level checks for the link-quality parser, bound to the top level.
`timescale 1ns / 1ps

module lqrp_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_stall,
	input logic [1:0] link_index,
	input logic [7:0] quality,
	input logic       out_valid,
	input logic       out_stall
);

	// Input back-pressure only comes from a held, stalled report.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("in_stall without a stalled output beat");

	// A new report is loaded only on a cycle where the input side was free.
	a_rise_free: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_stall))
		else $error("report loaded while input was stalled");

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid)
		else $error("out_valid dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> ($stable(link_index) && $stable(quality)))
		else $error("output payload changed while stalled");

endmodule

bind link_quality_report_parser_core lqrp_checker u_lqrp_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_stall   (in_stall),
	.link_index (link_index),
	.quality    (quality),
	.out_valid  (out_valid),
	.out_stall  (out_stall)
);

// ===== bench/link_report_checker.sv =====
// Checker for the link-quality line parser: predicts reports from accepted bytes and compares.
`timescale 1ns / 1ps

module link_report_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] rx_byte,
	input  logic       in_valid,
	input  logic       in_stall,
	input  logic [1:0] link_index,
	input  logic [7:0] quality,
	input  logic       out_valid,
	input  logic       out_stall,
	output int         reports_pending,
	output int         fail_count
);
	import lqrp_pkg::*;

	typedef struct packed {
		logic [1:0] link_idx;
		logic [7:0] level;
	} link_report_t;

	link_report_t quality_reports[$];
	link_report_t want;

	parse_state_t line_pos;
	logic [1:0]   seen_router;
	logic [1:0]   seen_link;
	logic [3:0]   first_nibble;

	initial fail_count = 0;

	// bit 4 set: not an uppercase hex digit
	function automatic logic [4:0] hex_digit(input logic [7:0] c);
		if (c >= CH_ZERO && c <= CH_NINE)
			return {1'b0, c[3:0]};
		if (c >= CH_UPPER_A && c <= CH_UPPER_F)
			return {1'b0, c[3:0] + 4'd9};
		return 5'h10;
	endfunction

	task automatic restart_line();
		line_pos     = ST_LEAD;
		seen_router  = ROUTER_NONE;
		seen_link    = 2'd0;
		first_nibble = 4'd0;
	endtask

	task automatic take_byte(input logic [7:0] c);
		logic [4:0]   digit;
		link_report_t found;
		digit = hex_digit(c);
		if (c == CH_NUL)
			return;
		if (c == CH_NEWLINE) begin
			restart_line();
			return;
		end
		case (line_pos)
		ST_LEAD:    if (c == CH_ZERO) line_pos = ST_ROUTER;
		ST_ROUTER: begin
			if (c == CH_ZERO || c == CH_ONE) begin
				seen_router = (c == CH_ONE) ? ROUTER_1 : ROUTER_0;
				line_pos    = ST_SKIP_A1;
			end
		end
		ST_SKIP_A1: line_pos = ST_SKIP_A2;
		ST_SKIP_A2: line_pos = ST_COLON_A;
		ST_COLON_A: if (c == CH_COLON) line_pos = ST_SKIP_B1;
		ST_SKIP_B1: line_pos = ST_SKIP_B2;
		ST_SKIP_B2: line_pos = ST_ZERO_B;
		ST_ZERO_B:  if (c == CH_ZERO) line_pos = ST_LINK;
		ST_LINK: begin
			if (c >= CH_TWO && c <= CH_FIVE) begin
				seen_link = 2'(c - CH_TWO);
				line_pos  = ST_COLON_C;
			end
		end
		ST_COLON_C: if (c == CH_COLON) line_pos = ST_HEX_HI;
		ST_HEX_HI: begin
			if (!digit[4]) begin
				first_nibble = digit[3:0];
				line_pos     = ST_HEX_LO;
			end
		end
		ST_HEX_LO: begin
			if (!digit[4]) begin
				// router 0 owns links 0/1, router 1 owns links 2/3
				if ((seen_router == ROUTER_0 && seen_link <= 2'd1) ||
				    (seen_router == ROUTER_1 && seen_link >= 2'd2)) begin
					found.link_idx = seen_link;
					found.level    = {first_nibble, digit[3:0]};
					quality_reports.push_back(found);
				end
				restart_line();
			end
		end
		default: ;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			restart_line();
			quality_reports.delete();
			reports_pending <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (quality_reports.size() == 0) begin
					$display({"%0t: ERROR unexpected report, expected none, ",
						"got link %0d quality 'h%02h"},
						$time, link_index, quality);
					fail_count++;
				end else begin
					want = quality_reports.pop_front();
					if (link_index !== want.link_idx) begin
						$display("%0t: ERROR link_index expected %0d, got %0d",
							$time, want.link_idx, link_index);
						fail_count++;
					end
					if (quality !== want.level) begin
						$display("%0t: ERROR quality expected 'h%02h, got 'h%02h",
							$time, want.level, quality);
						fail_count++;
					end
				end
			end
			if (in_valid && !in_stall)
				take_byte(rx_byte);
			reports_pending <= quality_reports.size();
		end
	end

endmodule

// ===== bench/tb_link_quality_report_parser_core.sv =====
// Testbench top for the link-quality line parser: byte stimulus, output stalls and verdict.
`timescale 1ns / 1ps

module tb_link_quality_report_parser_core;
	import lqrp_pkg::*;

	localparam int ITEMS       = 850;
	localparam int OPENING_LEN = 32;

	logic       clk;
	logic       arst_n;
	logic [7:0] rx_byte;
	logic       in_valid;
	logic       in_stall;
	logic [1:0] link_index;
	logic [7:0] quality;
	logic       out_valid;
	logic       out_stall;
	int         reports_pending;
	int         fail_count;

	bit no_idle = 1'b0;
	int bytes_sent = 0;

	// hand-built lines: ignored bytes while waiting for the first colon, the link digit
	// and the high hex digit, NULs, a cut line, lowercase hex, and both quality extremes
	logic [7:0] opening_bytes [0:OPENING_LEN-1] = '{
		CH_ZERO, CH_NUL, CH_ZERO, 8'hFF, CH_COLON, "a", CH_COLON, CH_ZERO,
		8'h80, CH_ZERO, "6", "3", CH_COLON, "a", CH_UPPER_F, CH_UPPER_F,
		CH_ZERO, CH_ONE, CH_NEWLINE,
		CH_ZERO, CH_ONE, CH_NUL, "x", "y", CH_COLON, "z", "z", CH_ZERO,
		CH_FIVE, CH_COLON, CH_ZERO, CH_ZERO
	};

	link_quality_report_parser_core uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.rx_byte    (rx_byte),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.link_index (link_index),
		.quality    (quality),
		.out_valid  (out_valid),
		.out_stall  (out_stall)
	);

	link_report_checker report_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.rx_byte         (rx_byte),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.link_index      (link_index),
		.quality         (quality),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.reports_pending (reports_pending),
		.fail_count      (fail_count)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic int pick_gap();
		int roll;
		if (no_idle)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		if (roll < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic logic [7:0] junk_byte();
		logic [7:0] b;
		do
			b = 8'($urandom_range(0, 255));
		while (b == CH_NEWLINE);
		return b;
	endfunction

	function automatic logic [7:0] random_hex_char();
		int v;
		v = $urandom_range(0, 15);
		if (v < 10)
			return CH_ZERO + 8'(v);
		return CH_UPPER_A + 8'(v - 10);
	endfunction

	// returns at the edge where the beat is taken
	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte  <= b;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		bytes_sent++;
	endtask

	task automatic send_field(input logic [7:0] ch, input bit noisy);
		int roll;
		roll = $urandom_range(0, 99);
		if (noisy && roll < 25)
			repeat ($urandom_range(1, 3)) send_byte(junk_byte());
		else if (noisy && roll < 28)
			send_byte(CH_NEWLINE);
		send_byte(ch);
	endtask

	task automatic send_report_line(input bit noisy);
		logic [7:0] router_ch;
		logic [7:0] link_ch;
		router_ch = $urandom_range(0, 1) ? CH_ONE : CH_ZERO;
		link_ch   = CH_TWO + 8'($urandom_range(0, 3));
		send_field(CH_ZERO, noisy);
		send_field(router_ch, noisy);
		send_byte(junk_byte());
		send_byte(junk_byte());
		send_field(CH_COLON, noisy);
		send_byte(junk_byte());
		send_byte(junk_byte());
		send_field(CH_ZERO, noisy);
		send_field(link_ch, noisy);
		send_field(CH_COLON, noisy);
		send_field(random_hex_char(), noisy);
		send_field(random_hex_char(), noisy);
	endtask

	initial begin
		int hold;
		int run;
		out_stall <= 1'b0;
		forever begin
			if (no_idle) begin
				out_stall <= 1'b0;
				@(posedge clk);
			end else begin
				hold = ($urandom_range(0, 99) < 35);
				run  = ($urandom_range(0, 99) < 92) ? $urandom_range(1, 3)
					: $urandom_range(10, 40);
				out_stall <= hold[0];
				repeat (run) @(posedge clk);
			end
		end
	end

	initial begin
		int roll;
		arst_n = 1'b0;
		in_valid <= 1'b0;
		rx_byte  <= CH_NUL;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < OPENING_LEN; i++)
			send_byte(opening_bytes[i]);

		while (bytes_sent < ITEMS) begin
			no_idle = ($urandom_range(0, 99) < 15);
			roll = $urandom_range(0, 99);
			if (roll < 80)
				send_report_line(roll < 40);
			else
				repeat ($urandom_range(1, 8)) send_byte(junk_byte());
			if ($urandom_range(0, 3) == 0)
				send_byte(CH_NEWLINE);
		end
		no_idle = 1'b0;
		in_valid <= 1'b0;

		do
			@(posedge clk);
		while (reports_pending != 0);
		repeat (8) @(posedge clk);

		if (fail_count == 0)
			$display("tb_link_quality_report_parser_core passed");
		else
			$display("tb_link_quality_report_parser_core failed");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("tb_link_quality_report_parser_core failed");
		$finish;
	end

endmodule
